/* hw/rtl/slt_pkg.sv */
// shared types, widths and codes for the sorted list table
package slt_pkg;

  localparam int DEPTH = 64;
  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = 7;
  localparam int LIM_EXT_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);

  typedef logic signed [31:0] entry_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] index;
    logic [6:0] count;
  } res_word_t;

  typedef struct packed {
    logic   compare;
    logic   insert;
    logic   remove;
    entry_t value;
  } cell_ctrl_t;

endpackage

/* hw/rtl/slt_cell.sv */
// one slot of the sorted table: compare flags and shift toward either neighbor
module slt_cell (
  input  logic               clk,
  input  slt_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  logic               left_lt,
  input  slt_pkg::entry_t    left_entry,
  input  slt_pkg::entry_t    right_entry,
  output slt_pkg::entry_t    entry,
  output logic               lt,
  output logic               eq
);
  import slt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      lt <= valid && (entry < ctrl.value);
      eq <= valid && (entry == ctrl.value);
    end
    // cells at or above the boundary move, the boundary cell takes the new value
    if (ctrl.insert && !lt) begin
      entry <= left_lt ? ctrl.value : left_entry;
    end else if (ctrl.remove && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

/* hw/rtl/sorted_list_table_unit.sv */
// top level of the sorted list table: sequencer, cell chain and result register
//
//   channel  signals                      direction  word
//   cmd      cmd_valid cmd_ready cmd_word in         cmd_word_t (cmd, value)
//   res      res_valid res_ready res_word out        res_word_t (status, index, count)
//   cfg      cfg_we cfg_wdata             in         capacity limit, 7 bits
//
// each word steps through accept, cell compare, boundary encode, shift and result;
// a new word is taken only in idle, also while the previous result still waits;
// the shift step holds while res is stalled
// rst clears the count, the sequencer and res_valid; the limit returns to 64
module sorted_list_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  slt_pkg::cmd_word_t cmd_word,
  output logic               res_valid,
  input  logic               res_ready,
  output slt_pkg::res_word_t res_word,
  input  logic               cfg_we,
  input  logic [slt_pkg::LIM_W-1:0] cfg_wdata
);
  import slt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_EXE  = 2'd3;

  logic [1:0]       state;
  cmd_word_t        cur;
  logic [CNT_W-1:0] count;
  logic [LIM_W-1:0] limit;
  logic [POS_W-1:0] pos;
  logic             found;

  cell_ctrl_t       ctrl;
  entry_t           entries [DEPTH];
  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] boundary;

  logic [LIM_EXT_W-1:0] lim_eff;
  logic                 full;
  logic                 commit;
  logic                 do_ins;
  logic                 do_rem;
  res_word_t            res_next;
  logic [CNT_W-1:0]     count_next;
  logic [POS_W-1:0]     pos_next;
  logic                 found_next;

  assign cmd_ready = (state == S_IDLE);
  assign commit    = (state == S_EXE) && (!res_valid || res_ready);

  // zero acts as one, anything above the built depth acts as the depth
  always_comb begin
    lim_eff = LIM_EXT_W'(limit);
    if (limit == '0) lim_eff = LIM_EXT_W'(1);
    if (LIM_EXT_W'(limit) > LIM_EXT_W'(DEPTH)) lim_eff = LIM_EXT_W'(DEPTH);
  end

  assign full   = LIM_EXT_W'(count) >= lim_eff;
  assign do_ins = commit && (cur.cmd == CMD_INSERT) && !full;
  assign do_rem = commit && (cur.cmd == CMD_REMOVE) && found;

  assign ctrl.compare = (state == S_CMP);
  assign ctrl.insert  = do_ins;
  assign ctrl.remove  = do_rem;
  assign ctrl.value   = cur.value;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic   valid_c;
      logic   left_lt_c;
      entry_t left_c;
      entry_t right_c;

      assign valid_c = CNT_W'(g) < count;
      if (g == 0) begin : g_first
        assign left_lt_c = 1'b1;
        assign left_c    = cur.value;
      end else begin : g_mid
        assign left_lt_c = lt[g-1];
        assign left_c    = entries[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_c = entries[g];
      end else begin : g_inner
        assign right_c = entries[g+1];
      end
      assign boundary[g] = !lt[g] && left_lt_c;

      slt_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (valid_c),
        .left_lt     (left_lt_c),
        .left_entry  (left_c),
        .right_entry (right_c),
        .entry       (entries[g]),
        .lt          (lt[g]),
        .eq          (eq[g])
      );
    end
  endgenerate

  // lt flags form a prefix, so at most one boundary bit is set
  always_comb begin
    pos_next   = '0;
    found_next = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (boundary[i]) pos_next = pos_next | POS_W'(i);
      found_next = found_next | (boundary[i] & eq[i]);
    end
  end

  always_comb begin
    res_next   = '0;
    count_next = count;
    case (cur.cmd)
      CMD_INSERT: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status = ST_DONE;
          res_next.index  = 6'(pos);
          count_next      = count + CNT_W'(1);
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (count == '0) begin
          res_next.status = ST_EMPTY;
        end else if (!found) begin
          res_next.status = ST_MISSING;
        end else begin
          res_next.status = ST_DONE;
          res_next.index  = 6'(pos);
          if (cur.cmd == CMD_REMOVE) count_next = count - CNT_W'(1);
        end
      end
      default: begin
        res_next.status = ST_DONE;
      end
    endcase
    res_next.count = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      limit     <= LIMIT_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) state <= S_CMP;
        end
        S_CMP: begin
          state <= S_FIND;
        end
        S_FIND: begin
          state <= S_EXE;
        end
        S_EXE: begin
          if (commit) begin
            count     <= count_next;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) cur <= cmd_word;
    if (state == S_FIND) begin
      pos   <= pos_next;
      found <= found_next;
    end
    if (commit) res_word <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_rise_from_exe: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_EXE)
    else $error("result raised outside the shift step");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_rem |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the count");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.status != ST_DONE |-> res_word.index == '0)
    else $error("failed word carries a nonzero index");

endmodule

/* bench/sorted_list_table_unit_test.sv */
// self-checking testbench for the sorted list table unit
`timescale 1ns / 1ps

module sorted_list_table_unit_test;
  import slt_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam entry_t VAL_MIN = entry_t'(32'h8000_0000);
  localparam entry_t VAL_MAX = entry_t'(32'h7fff_ffff);
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;

  // sorted copy of the table and the results it implies
  class list_scoreboard;
    entry_t held[$];
    int limit = 64;
    res_word_t waiting[$];
    int errors;
    int results;
    int n_full;
    int n_empty;
    int n_missing;

    function void set_limit(int l);
      limit = l;
    endfunction

    function void note_word(cmd_word_t w);
      res_word_t r;
      int eff;
      int pos;
      eff = (limit < 1) ? 1 : (limit > DEPTH) ? DEPTH : limit;
      r.status = ST_DONE;
      pos = 0;
      if (w.cmd == CMD_INSERT) begin
        if (held.size() >= eff) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held.size() && held[pos] < w.value) pos++;
          held.insert(pos, w.value);
        end
      end else if (w.cmd == CMD_REMOVE || w.cmd == CMD_SEARCH) begin
        if (held.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (pos < held.size() && held[pos] != w.value) pos++;
          if (pos == held.size()) begin
            r.status = ST_MISSING;
            pos = 0;
          end else if (w.cmd == CMD_REMOVE) begin
            held.delete(pos);
          end
        end
      end
      r.index = pos[5:0];
      r.count = 7'(held.size());
      waiting.push_back(r);
    endfunction

    function void check_word(res_word_t got);
      res_word_t want;
      if (waiting.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: status %0d index %0d count %0d",
                 $time, got.status, got.index, got.count);
        return;
      end
      want = waiting.pop_front();
      results++;
      if (want.status == ST_FULL) n_full++;
      if (want.status == ST_EMPTY) n_empty++;
      if (want.status == ST_MISSING) n_missing++;
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.index !== want.index) begin
        errors++;
        $display("%0t: index mismatch: expected %0d, actual %0d",
                 $time, want.index, got.index);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: count mismatch: expected %0d, actual %0d",
                 $time, want.count, got.count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_word_t cmd_word;
  logic res_valid;
  logic res_ready;
  res_word_t res_word;
  logic cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  list_scoreboard sb = new();
  int gap_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  sorted_list_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_word (cmd_word),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_word (res_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) sb.note_word(cmd_word);
      if (res_valid && res_ready) sb.check_word(res_word);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
          $display("sorted_list_table_unit test failed");
          $finish;
        end
      end
    end
  end

  function automatic cmd_word_t mk(logic [1:0] c, entry_t v);
    cmd_word_t w;
    w.cmd = c;
    w.value = v;
    return w;
  endfunction

  function automatic cmd_word_t random_word(int ins_pct);
    cmd_word_t w;
    int r;
    r = $urandom_range(99);
    if (r < 3) w.cmd = CMD_NOP;
    else if (r < 3 + ins_pct) w.cmd = CMD_INSERT;
    else if (r[0]) w.cmd = CMD_REMOVE;
    else w.cmd = CMD_SEARCH;
    // small values and stored values so remove and search often hit
    r = $urandom_range(99);
    if (r < 35) begin
      w.value = entry_t'($urandom_range(16)) - 8;
    end else if (r < 45) begin
      case ($urandom_range(3))
        0: w.value = VAL_MIN;
        1: w.value = VAL_MAX;
        2: w.value = VAL_MIN + 1;
        default: w.value = VAL_MAX - 1;
      endcase
    end else if (r < 75 && sb.held.size() != 0) begin
      w.value = sb.held[$urandom_range(sb.held.size() - 1)];
    end else begin
      w.value = $urandom;
    end
    return w;
  endfunction

  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (sb.waiting.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // limit is only changed once the table has gone quiet
  task automatic write_limit(input int l);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= LIM_W'(l);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(l & 127);
  endtask

  task automatic run_phase(input int l, input int gap, input int stall, input int n,
                           input int ins_pct, input bit hold);
    write_limit(l);
    gap_pct = gap;
    stall_pct = stall;
    if (hold) hold_req = 1'b1;
    repeat (n) send_word(random_word(ins_pct));
  endtask

  initial begin
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd_word <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, unused command, extremes, duplicates, misses
    send_word(mk(CMD_SEARCH, 0));
    send_word(mk(CMD_REMOVE, 0));
    send_word(mk(CMD_NOP, 5));
    send_word(mk(CMD_INSERT, 0));
    send_word(mk(CMD_INSERT, VAL_MAX));
    send_word(mk(CMD_INSERT, VAL_MIN));
    send_word(mk(CMD_INSERT, 0));
    send_word(mk(CMD_INSERT, -1));
    send_word(mk(CMD_SEARCH, 0));
    send_word(mk(CMD_SEARCH, 5));
    send_word(mk(CMD_REMOVE, 5));
    send_word(mk(CMD_REMOVE, 0));
    send_word(mk(CMD_SEARCH, VAL_MIN));
    send_word(mk(CMD_SEARCH, VAL_MAX));
    send_word(mk(CMD_REMOVE, VAL_MAX));
    send_word(mk(CMD_NOP, -1));
    // limit zero, already below the count: inserts are refused
    write_limit(0);
    send_word(mk(CMD_INSERT, 3));
    send_word(mk(CMD_REMOVE, VAL_MIN));
    send_word(mk(CMD_SEARCH, -1));

    // limit, sender gap %, receiver stall %, words, insert %, long hold-off
    run_phase(127, 0, 0, 300, 70, 1'b1);
    run_phase(5, 85, 0, 200, 50, 1'b0);
    run_phase(0, 0, 85, 150, 50, 1'b0);
    run_phase(1, 38, 38, 150, 50, 1'b0);
    run_phase(20, 38, 38, 250, 55, 1'b0);
    run_phase(64, 0, 85, 300, 65, 1'b0);
    run_phase(40, 85, 0, 200, 35, 1'b0);
    run_phase(64, 0, 0, 300, 60, 1'b1);

    wait_drained();
    $display("checked %0d results under limits 0, 1, 5, 20, 40, 64 and 127", sb.results);
    $display("%0d full, %0d empty, %0d not found; long receiver hold-offs twice",
             sb.n_full, sb.n_empty, sb.n_missing);
    if (sb.errors == 0) begin
      $display("sorted_list_table_unit test passed");
    end else begin
      $display("sorted_list_table_unit test failed");
    end
    $finish;
  end

endmodule
